// File: rtl/ctpp_pkg.sv
package ctpp_pkg;

    localparam int CordicItersDef = 16;

    // configuration register indexes
    localparam logic [1:0] REG_HEIGHT = 2'd0;
    localparam logic [1:0] REG_TILT   = 2'd1;
    localparam logic [1:0] REG_DEPTH  = 2'd2;

    // operand and datapath widths
    localparam int MulAW  = 17;
    localparam int MulBW  = 31;
    localparam int MulPW  = MulAW + MulBW;
    localparam int SqrtVW = 36;
    localparam int SqrtRW = SqrtVW / 2;
    localparam int CdXW   = 36;
    localparam int CdZW   = 21;

    localparam logic signed [CdXW-1:0] InvGainQ30 = 36'sd652032874;
    localparam logic signed [CdZW-1:0] Q16Pi      = 21'sd205887;

    // atan(2^-i) in Q16
    function automatic logic [15:0] atan_q16(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/ctpp_mul.sv
module ctpp_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [ctpp_pkg::MulAW-1:0]    i_a,
    input  logic [ctpp_pkg::MulBW-1:0]    i_b,
    output logic [ctpp_pkg::MulPW-1:0]    o_p,
    output logic                          o_done
);
    import ctpp_pkg::*;

    logic [MulAW-1:0] r_a;
    logic [MulPW-1:0] r_b;
    logic [MulPW-1:0] r_acc;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic             r_done;

    // one multiplier bit per cycle, LSB first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_a    <= i_a;
                r_b    <= MulPW'(i_b);
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_a[0])
                    r_acc <= r_acc + r_b;
                r_a   <= r_a >> 1;
                r_b   <= r_b << 1;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(MulAW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_p    = r_acc;
    assign o_done = r_done;

endmodule

// File: rtl/ctpp_sqrt.sv
module ctpp_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [ctpp_pkg::SqrtVW-1:0]   i_v,
    output logic [ctpp_pkg::SqrtRW-1:0]   o_root,
    output logic                          o_done
);
    import ctpp_pkg::*;

    logic [SqrtVW-1:0] r_v;
    logic [SqrtRW+2:0] r_rem;
    logic [SqrtRW-1:0] r_root;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [SqrtRW+2:0] rem_sh;
    logic [SqrtRW+2:0] trial;

    // two radicand bits per cycle, restoring
    assign rem_sh = {r_rem[SqrtRW:0], r_v[SqrtVW-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_v    <= i_v;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_v <= r_v << 2;
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[SqrtRW-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[SqrtRW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(SqrtRW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

// File: rtl/ctpp_cordic.sv
module ctpp_cordic #(
    parameter int ITERS = ctpp_pkg::CordicItersDef
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_go,
    input  logic                                i_vec,
    input  logic signed [ctpp_pkg::CdXW-1:0]    i_x,
    input  logic signed [ctpp_pkg::CdXW-1:0]    i_y,
    input  logic signed [ctpp_pkg::CdZW-1:0]    i_z,
    output logic signed [ctpp_pkg::CdXW-1:0]    o_x,
    output logic signed [ctpp_pkg::CdZW-1:0]    o_z,
    output logic                                o_done
);
    import ctpp_pkg::*;

    localparam int CntW = $clog2(ITERS + 1);

    logic signed [CdXW-1:0] r_x;
    logic signed [CdXW-1:0] r_y;
    logic signed [CdZW-1:0] r_z;
    logic                   r_vec;
    logic [CntW-1:0]        r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic signed [CdXW-1:0] xs;
    logic signed [CdXW-1:0] ys;
    logic signed [CdZW-1:0] at;
    logic                   up;

    assign xs = r_x >>> r_cnt;
    assign ys = r_y >>> r_cnt;
    assign at = CdZW'(atan_q16(5'(r_cnt)));
    // vectoring drives y to zero, rotation drives z to zero
    assign up = r_vec ? r_y[CdXW-1] : ~r_z[CdZW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_x    <= i_x;
                r_y    <= i_y;
                r_z    <= i_z;
                r_vec  <= i_vec;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (up) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_x    = r_x;
    assign o_z    = r_z;
    assign o_done = r_done;

endmodule

// File: rtl/camera_target_polar_position_unit.sv
// Turns one camera detection (side offset, forward offset, slant range) into a
// stored ground distance and bearing about the robot centre, and returns one
// result per detection with the stored bearing in degrees, the distance and
// flags. One detection at a time: the next is accepted only once the last
// result has been moved into the output register, which can wait on the
// receiver. Slant mode takes three products and a square root, tilted mode a
// CORDIC cosine and one product; accepted detections then take two products, a
// square root and, unless the point is at the origin, a CORDIC bearing. The
// shared bit-serial multiplier (up to five products), the two-bit-a-cycle
// square-root unit, the CORDIC unit (CORDIC_ITERS iterations) and a restoring
// division for the degree conversion do the work. A finished result waits in
// the output register while the next detection is taken in.
module camera_target_polar_position_unit #(
    parameter int CORDIC_ITERS = ctpp_pkg::CordicItersDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // offset_x[15:0], offset_y[31:16], slant_range[47:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // bearing_deg[8:0], ground_dist[25:9], zero fill
    output logic [1:0]  m_axis_tuser,   // accepted[0], pos_valid[1]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data
);
    import ctpp_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DEC  = 5'd1;
    localparam logic [4:0] S_RR   = 5'd2;
    localparam logic [4:0] S_HH   = 5'd3;
    localparam logic [4:0] S_XX   = 5'd4;
    localparam logic [4:0] S_SQ1  = 5'd5;
    localparam logic [4:0] S_COS  = 5'd6;
    localparam logic [4:0] S_PX   = 5'd7;
    localparam logic [4:0] S_CTR  = 5'd8;
    localparam logic [4:0] S_SS   = 5'd9;
    localparam logic [4:0] S_CC   = 5'd10;
    localparam logic [4:0] S_SQ2  = 5'd11;
    localparam logic [4:0] S_ATN  = 5'd12;
    localparam logic [4:0] S_DEG  = 5'd13;
    localparam logic [4:0] S_DIV  = 5'd14;
    localparam logic [4:0] S_OUT  = 5'd15;

    localparam logic [15:0] TiltLimit  = 16'd3215;
    localparam int          CosBase    = 6431;
    localparam int          Q12Pi      = 12868;
    localparam int          Q12HalfPi  = 6434;
    localparam logic [31:0] MinGroundSq = 32'd10000;
    localparam logic [17:0] DistMax    = 18'd131071;
    localparam logic [23:0] DegDiv     = 24'd80384;

    // bring a signed Q4.12 angle into [-pi/2, pi/2]; bit 17 flags a sign flip
    function automatic logic [17:0] reduce(input logic signed [16:0] a_in);
        logic signed [16:0] a;
        logic               neg;
        a   = a_in;
        neg = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (a > 17'(Q12HalfPi)) begin
                a   = a - 17'(Q12Pi);
                neg = ~neg;
            end else if (a < -17'(Q12HalfPi)) begin
                a   = a + 17'(Q12Pi);
                neg = ~neg;
            end
        end
        return {neg, a};
    endfunction

    logic [4:0]         r_state;
    logic [11:0]        r_height;
    logic signed [14:0] r_tilt;
    logic signed [12:0] r_depth;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic [15:0]        r_r;
    logic               r_cneg;
    logic [31:0]        r_r2;
    logic [31:0]        r_g2;
    logic [MulPW-1:0]   r_ss;
    logic signed [15:0] r_s;
    logic signed [17:0] r_c;
    logic [16:0]        r_dist;
    logic signed [15:0] r_st_angle;
    logic [16:0]        r_st_dist;
    logic               r_have;
    logic               r_ok;
    logic [23:0]        r_num;
    logic [7:0]         r_quo;
    logic [2:0]         r_k;
    logic               r_aneg;
    logic               r_ovalid;
    logic [8:0]         r_odeg;
    logic [16:0]        r_odist;
    logic               r_oacc;
    logic               r_ohave;

    logic               r_mul_go;
    logic [MulAW-1:0]   r_ma;
    logic [MulBW-1:0]   r_mb;
    logic               r_sq_go;
    logic [SqrtVW-1:0]  r_sq_v;
    logic               r_cd_go;
    logic               r_cd_vec;
    logic signed [CdXW-1:0] r_cd_x;
    logic signed [CdXW-1:0] r_cd_y;
    logic signed [CdZW-1:0] r_cd_z;

    logic [MulPW-1:0]       mul_p;
    logic                   mul_done;
    logic [SqrtRW-1:0]      sq_root;
    logic                   sq_done;
    logic signed [CdXW-1:0] cd_x;
    logic signed [CdZW-1:0] cd_z;
    logic                   cd_done;

    logic [15:0]        tilt_abs;
    logic [16:0]        x_abs;
    logic [16:0]        s_abs;
    logic [17:0]        c_abs;
    logic [17:0]        red;
    logic [CdXW-1:0]    cos_abs;
    logic [17:0]        q;
    logic signed [17:0] c_rec;
    logic [SqrtVW-1:0]  sum_sq;
    logic signed [CdZW-1:0] z_rnd;
    logic [16:0]        ang_abs;
    logic [27:0]        num_full;
    logic [23:0]        div_d;

    ctpp_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_mul_go),
        .i_a    (r_ma),
        .i_b    (r_mb),
        .o_p    (mul_p),
        .o_done (mul_done)
    );

    ctpp_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_sq_go),
        .i_v    (r_sq_v),
        .o_root (sq_root),
        .o_done (sq_done)
    );

    ctpp_cordic #(
        .ITERS(CORDIC_ITERS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_cd_go),
        .i_vec  (r_cd_vec),
        .i_x    (r_cd_x),
        .i_y    (r_cd_y),
        .i_z    (r_cd_z),
        .o_x    (cd_x),
        .o_z    (cd_z),
        .o_done (cd_done)
    );

    always_comb begin
        tilt_abs = r_tilt[14] ? -16'(r_tilt) : 16'(r_tilt);
        x_abs    = r_x[15] ? -17'(r_x) : 17'(r_x);
        s_abs    = r_s[15] ? -17'(r_s) : 17'(r_s);
        c_abs    = r_c[17] ? -r_c : r_c;
        red      = reduce(17'(CosBase) - 17'(r_tilt));
        cos_abs  = cd_x[CdXW-1] ? -cd_x : cd_x;
        q        = mul_p[47:30];
        c_rec    = r_c - 18'(r_depth);
        sum_sq   = SqrtVW'(r_ss) + SqrtVW'(mul_p);
        z_rnd    = (cd_z + CdZW'(8)) >>> 4;
        ang_abs  = r_st_angle[15] ? -17'(r_st_angle) : 17'(r_st_angle);
        num_full = {11'd0, ang_abs} * 28'd1125;
        div_d    = DegDiv << r_k;
    end

    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height   <= '0;
            r_tilt     <= '0;
            r_depth    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HEIGHT: r_height <= i_cfg_data[11:0];
                REG_TILT:   r_tilt   <= i_cfg_data;
                REG_DEPTH:  r_depth  <= i_cfg_data[12:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_st_angle <= '0;
            r_st_dist  <= '0;
            r_have     <= 1'b0;
            r_ovalid   <= 1'b0;
            r_mul_go   <= 1'b0;
            r_sq_go    <= 1'b0;
            r_cd_go    <= 1'b0;
        end else begin
            r_mul_go <= 1'b0;
            r_sq_go  <= 1'b0;
            r_cd_go  <= 1'b0;
            if (r_ovalid && m_axis_tready)
                r_ovalid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_x     <= s_axis_tdata[15:0];
                        r_y     <= s_axis_tdata[31:16];
                        r_r     <= s_axis_tdata[47:32];
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (tilt_abs <= TiltLimit) begin
                        if (16'(r_height) > r_r) begin
                            r_ok    <= 1'b0;
                            r_state <= S_DEG;
                        end else begin
                            r_ok     <= 1'b1;
                            r_ma     <= MulAW'(r_r);
                            r_mb     <= MulBW'(r_r);
                            r_mul_go <= 1'b1;
                            r_state  <= S_RR;
                        end
                    end else begin
                        r_ok     <= 1'b1;
                        r_cneg   <= red[17];
                        r_cd_vec <= 1'b0;
                        r_cd_x   <= InvGainQ30;
                        r_cd_y   <= '0;
                        r_cd_z   <= CdZW'(signed'(red[16:0])) <<< 4;
                        r_cd_go  <= 1'b1;
                        r_state  <= S_COS;
                    end
                end
                S_RR: begin
                    if (mul_done) begin
                        r_r2     <= mul_p[31:0];
                        r_ma     <= MulAW'(r_height);
                        r_mb     <= MulBW'(r_height);
                        r_mul_go <= 1'b1;
                        r_state  <= S_HH;
                    end
                end
                S_HH: begin
                    if (mul_done) begin
                        r_g2     <= r_r2 - mul_p[31:0];
                        r_ma     <= x_abs;
                        r_mb     <= MulBW'(x_abs);
                        r_mul_go <= 1'b1;
                        r_state  <= S_XX;
                    end
                end
                S_XX: begin
                    if (mul_done) begin
                        if (r_g2 < MinGroundSq || mul_p[31:0] > r_g2) begin
                            r_ok    <= 1'b0;
                            r_state <= S_DEG;
                        end else begin
                            r_sq_v  <= SqrtVW'(r_g2 - mul_p[31:0]);
                            r_sq_go <= 1'b1;
                            r_state <= S_SQ1;
                        end
                    end
                end
                S_SQ1: begin
                    if (sq_done) begin
                        r_c     <= 18'(sq_root[15:0]);
                        r_s     <= r_x;
                        r_state <= S_CTR;
                    end
                end
                S_COS: begin
                    if (cd_done) begin
                        // sign of x * cos, taken apart from the magnitude
                        r_cneg   <= r_x[15] ^ r_cneg ^ cd_x[CdXW-1];
                        r_ma     <= x_abs;
                        r_mb     <= cos_abs[MulBW-1:0];
                        r_mul_go <= 1'b1;
                        r_state  <= S_PX;
                    end
                end
                S_PX: begin
                    if (mul_done) begin
                        r_c     <= r_cneg ? -q : q;
                        r_s     <= r_y;
                        r_state <= S_CTR;
                    end
                end
                S_CTR: begin
                    r_c      <= c_rec;
                    r_ma     <= s_abs;
                    r_mb     <= MulBW'(s_abs);
                    r_mul_go <= 1'b1;
                    r_state  <= S_SS;
                end
                S_SS: begin
                    if (mul_done) begin
                        r_ss     <= mul_p;
                        r_ma     <= c_abs[16:0];
                        r_mb     <= MulBW'(c_abs);
                        r_mul_go <= 1'b1;
                        r_state  <= S_CC;
                    end
                end
                S_CC: begin
                    if (mul_done) begin
                        r_sq_v  <= sum_sq;
                        r_sq_go <= 1'b1;
                        r_state <= S_SQ2;
                    end
                end
                S_SQ2: begin
                    if (sq_done) begin
                        r_dist <= (sq_root > DistMax) ? DistMax[16:0] : sq_root[16:0];
                        if (r_s == '0 && r_c == '0) begin
                            r_st_dist  <= (sq_root > DistMax) ? DistMax[16:0]
                                                              : sq_root[16:0];
                            r_st_angle <= '0;
                            r_have     <= 1'b1;
                            r_state    <= S_DEG;
                        end else begin
                            r_cd_vec <= 1'b1;
                            // c < 0: pre-rotate by pi
                            if (r_c[17]) begin
                                r_cd_x <= -(CdXW'(r_c) <<< 16);
                                r_cd_y <= -(CdXW'(r_s) <<< 16);
                                r_cd_z <= r_s[15] ? -Q16Pi : Q16Pi;
                            end else begin
                                r_cd_x <= CdXW'(r_c) <<< 16;
                                r_cd_y <= CdXW'(r_s) <<< 16;
                                r_cd_z <= '0;
                            end
                            r_cd_go <= 1'b1;
                            r_state <= S_ATN;
                        end
                    end
                end
                S_ATN: begin
                    if (cd_done) begin
                        r_st_angle <= z_rnd[15:0];
                        r_st_dist  <= r_dist;
                        r_have     <= 1'b1;
                        r_state    <= S_DEG;
                    end
                end
                S_DEG: begin
                    r_num   <= num_full[23:0];
                    r_aneg  <= r_st_angle[15];
                    r_quo   <= '0;
                    r_k     <= 3'd7;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring division by a constant, one quotient bit a cycle
                    if (r_num >= div_d) begin
                        r_num <= r_num - div_d;
                        r_quo <= {r_quo[6:0], 1'b1};
                    end else begin
                        r_quo <= {r_quo[6:0], 1'b0};
                    end
                    r_k <= r_k - 3'd1;
                    if (r_k == 3'd0)
                        r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odeg   <= r_aneg ? -9'(r_quo) : 9'(r_quo);
                        r_odist  <= r_st_dist;
                        r_oacc   <= r_ok;
                        r_ohave  <= r_have;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_odist, r_odeg};
    assign m_axis_tuser  = {r_ohave, r_oacc};

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ctpp_pkg::*;

    typedef struct packed {
        logic               accepted;
        logic               pos_valid;
        logic signed [8:0]  bearing_deg;
        logic [16:0]        ground_dist;
    } t_polar;

    localparam int ITERS = ctpp_pkg::CordicItersDef;
    localparam int TILT_LIMIT = 3215;
    localparam int CYCLE_LIMIT = 2000000;

    class polar_scoreboard;
        t_polar pending_q[$];
        int     n_fail;
        // block-side configuration and stored position
        longint height, tilt, depth;
        longint angle_q12, dist_mm;
        bit     have_pos;

        function new();
            n_fail = 0;
            height = 0; tilt = 0; depth = 0;
            angle_q12 = 0; dist_mm = 0; have_pos = 0;
        endfunction

        function longint shr(longint v, int s);
            return v >>> s;
        endfunction

        function longint root(longint v);
            longint r, b;
            r = 0;
            b = 64'sd1 <<< 62;
            while (b > v) b = b >>> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >>> 1) + b;
                end else begin
                    r = r >>> 1;
                end
                b = b >>> 2;
            end
            return r;
        endfunction

        function longint cosine_q30(longint a);
            bit     neg;
            longint x, y, z, nx;
            neg = 0;
            for (int k = 0; k < 3; k++) begin
                if (a > 6434) begin
                    a -= 12868; neg = !neg;
                end else if (a < -6434) begin
                    a += 12868; neg = !neg;
                end
            end
            x = 652032874; y = 0; z = a * 16;
            for (int i = 0; i < ITERS && i < 24; i++) begin
                if (z >= 0) begin
                    nx = x - shr(y, i); y = y + shr(x, i);
                    z -= longint'(ctpp_pkg::atan_q16(5'(i)));
                end else begin
                    nx = x + shr(y, i); y = y - shr(x, i);
                    z += longint'(ctpp_pkg::atan_q16(5'(i)));
                end
                x = nx;
            end
            return neg ? -x : x;
        endfunction

        function longint bearing_q12(longint s, longint c);
            longint x, y, z, nx;
            if (s == 0 && c == 0) return 0;
            x = c <<< 16; y = s <<< 16; z = 0;
            if (c < 0) begin
                x = -x; y = -y;
                z = (s >= 0) ? 205887 : -205887;
            end
            for (int i = 0; i < ITERS && i < 24; i++) begin
                if (y < 0) begin
                    nx = x - shr(y, i); y = y + shr(x, i);
                    z -= longint'(ctpp_pkg::atan_q16(5'(i)));
                end else begin
                    nx = x + shr(y, i); y = y - shr(x, i);
                    z += longint'(ctpp_pkg::atan_q16(5'(i)));
                end
                x = nx;
            end
            return shr(z + 8, 4);
        endfunction

        function void set_reg(logic [1:0] idx, logic [14:0] v);
            case (idx)
                REG_HEIGHT: height = longint'(v[11:0]);
                REG_TILT:   tilt = longint'($signed(v));
                REG_DEPTH:  depth = longint'($signed(v[12:0]));
                default: ;
            endcase
        endfunction

        function void note_detection(logic [47:0] d);
            longint x, y, r, g2, x2, s, c, p, q, dd, mag, deg;
            bit     ok;
            t_polar e;
            x = longint'($signed(d[15:0]));
            y = longint'($signed(d[31:16]));
            r = longint'(d[47:32]);
            ok = 1; s = 0; c = 0;
            if ((tilt < 0 ? -tilt : tilt) <= TILT_LIMIT) begin
                if (height > r) begin
                    ok = 0;
                end else begin
                    g2 = r * r - height * height;
                    x2 = x * x;
                    if (g2 < 10000 || x2 > g2) ok = 0;
                    else begin
                        s = x; c = root(g2 - x2);
                    end
                end
            end else begin
                p = x * cosine_q30(6431 - tilt);
                q = (p < 0 ? -p : p) >>> 30;
                s = y;
                c = p < 0 ? -q : q;
            end
            if (ok) begin
                c -= depth;
                dd = root(s * s + c * c);
                dist_mm = dd > 131071 ? 131071 : dd;
                angle_q12 = bearing_q12(s, c);
                have_pos = 1;
            end
            mag = angle_q12 < 0 ? -angle_q12 : angle_q12;
            deg = (mag * 1125) / 80384;
            if (angle_q12 < 0) deg = -deg;
            e.accepted = ok;
            e.pos_valid = have_pos;
            e.bearing_deg = 9'(deg);
            e.ground_dist = 17'(dist_mm);
            pending_q.push_back(e);
        endfunction

        function void check_result(t_polar got);
            t_polar e;
            if (pending_q.size() == 0) begin
                $error("unexpected result %p", got);
                n_fail++;
                return;
            end
            e = pending_q.pop_front();
            if (got.accepted !== e.accepted) begin
                $error("accepted exp %0d got %0d", e.accepted, got.accepted); n_fail++;
            end
            if (got.pos_valid !== e.pos_valid) begin
                $error("pos_valid exp %0d got %0d", e.pos_valid, got.pos_valid); n_fail++;
            end
            if (got.bearing_deg !== e.bearing_deg) begin
                $error("bearing_deg exp %0d got %0d", e.bearing_deg, got.bearing_deg);
                n_fail++;
            end
            if (got.ground_dist !== e.ground_dist) begin
                $error("ground_dist exp %0d got %0d", e.ground_dist, got.ground_dist);
                n_fail++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_idx = '0;
    logic [14:0] i_cfg_data = '0;

    polar_scoreboard sb = new();
    int  cycle_cnt = 0;
    bit  hold_off = 0;

    camera_target_polar_position_unit dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result({m_axis_tuser[0], m_axis_tuser[1],
                             m_axis_tdata[8:0], m_axis_tdata[25:9]});
    end

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 3);
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial begin
        int g;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 0;
                repeat (2000) @(posedge i_clk);
                hold_off = 0;
            end
            g = (cycle_cnt % 40000 < 8000) ? 0 : gap_len();
            if (g > 0) begin
                m_axis_tready <= 0;
                repeat (g) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [14:0] v);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
        sb.set_reg(idx, v);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // tvalid stays high after the transfer; drain drops it, and so does the next send when it inserts a gap
    task automatic send(logic signed [15:0] x, logic signed [15:0] y, logic [15:0] r,
                        bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {r, y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_detection({r, y, x});
    endtask

    task automatic random_detection(bit gaps);
        logic [15:0] r, x, y;
        int          mode;
        mode = $urandom_range(0, 9);
        y = 16'($urandom);
        if (mode < 6) begin
            // mostly geometry that passes the slant checks
            r = 16'($urandom_range(sb.height + 101, 65535));
            x = 16'($urandom_range(0, r / 2));
            if ($urandom_range(0, 1)) x = -x;
        end else begin
            r = 16'($urandom);
            x = 16'($urandom);
        end
        send(x, y, r, gaps);
    endtask

    initial begin
        int tilts [6];
        tilts = '{0, 3215, -3215, 3216, 12868, -12868};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: slant mode, defaults
        send(0, 0, 0, 0);            // too short, nothing stored yet
        send(0, 0, 100, 0);          // ground exactly 100
        send(0, 0, 99, 0);
        send(100, 5, 100, 0);        // offset equals ground
        send(101, 5, 100, 0);        // offset beyond ground
        send(-32768, 32767, 65535, 0);
        send(32767, -32768, 65535, 0);
        send(0, 0, 65535, 0);
        drain();
        write_reg(REG_HEIGHT, 15'd4095);
        write_reg(REG_DEPTH, 15'h1000);  // -4096
        send(0, 0, 4094, 0);         // height above range
        send(10, 0, 4095, 0);
        send(-500, 0, 65535, 0);
        drain();
        write_reg(REG_TILT, 15'(12868));
        write_reg(REG_DEPTH, 15'd4095);
        send(0, 0, 0, 0);
        send(4095, 0, 1, 0);         // tiny cosine, forward leg set by the depth
        send(-32768, -32768, 0, 0);
        send(32767, 32767, 65535, 0);
        send(0, 1, 7, 0);
        drain();
        write_reg(REG_TILT, 15'(-12868));
        send(-32768, 32767, 3, 0);
        send(32767, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_TILT, 15'(ph == 5 ? $urandom_range(0, 32767) : tilts[ph]));
            write_reg(REG_HEIGHT, 15'($urandom_range(0, 4095)));
            write_reg(REG_DEPTH, 15'($urandom));
            if (ph == 2) hold_off = 1;
            for (int n = 0; n < 125; n++) random_detection(1);
            drain();
        end

        drain();
        if (sb.n_fail == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// File: filelist.f
rtl/ctpp_pkg.sv
rtl/ctpp_mul.sv
rtl/ctpp_sqrt.sv
rtl/ctpp_cordic.sv
rtl/camera_target_polar_position_unit.sv
tb/tb.sv
